@@ rtl/core/mtcsi_pkg.sv @@
// ----------------------------------------------------------------------------
// mtcsi_pkg
// Shared types, constants and helpers of the multi-threshold CSI compare block.
// ----------------------------------------------------------------------------
package mtcsi_pkg;

    localparam int SLOTS       = 4;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int SLOT_IDX_W  = $clog2(2 * SLOTS);
    localparam int SAMPLE_W    = 16;
    localparam int WEIGHT_W    = 16;
    localparam int CSI_W       = 16;
    localparam int CSI_FRAC    = 15;
    localparam int TOTAL_W     = 18;
    localparam int PROD_W      = CSI_W + WEIGHT_W;
    localparam int ACC_W       = PROD_W + SLOT_W;
    localparam int DIGIT_W     = 4;
    localparam int NUM_DIGITS  = SAMPLE_W / DIGIT_W;
    localparam int DCNT_W      = $clog2(NUM_DIGITS);
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    localparam int DEF_NUM_THRESHOLDS   = 4;
    localparam int DEF_POINT_COUNT_LOG2 = 20;

    localparam logic [WEIGHT_W-1:0] WEIGHT0_RESET = WEIGHT_W'(4096);

    typedef logic [SLOTS-1:0][SAMPLE_W-1:0] thr_vec_t;

    typedef struct packed {
        logic [SLOTS-1:0] obs;
        logic [SLOTS-1:0] plain;
        logic [SLOTS-1:0] adj;
    } yes_flags_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD_0,
        REG_THRESHOLD_1,
        REG_THRESHOLD_2,
        REG_THRESHOLD_3,
        REG_WEIGHT_0,
        REG_WEIGHT_1,
        REG_WEIGHT_2,
        REG_WEIGHT_3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CMP,
        ST_DIV_START,
        ST_DIV,
        ST_MUL,
        ST_ACC,
        ST_NEXT,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic s_ready;
        logic cmp_start;
        logic cnt_upd;
        logic div_start;
        logic csi_wr;
        logic mul_en;
        logic acc_en;
        logic slot_inc;
        logic out_load;
    } ctrl_t;

    // one digit of a serial greater-than, the top digit carries the sign
    function automatic logic dig_gt(
        input logic [DIGIT_W-1:0] a,
        input logic [DIGIT_W-1:0] b,
        input logic               top
    );
        logic res;
        if (top) begin
            res = $signed(a) > $signed(b);
        end else begin
            res = a > b;
        end
        return res;
    endfunction

endpackage

@@ rtl/core/mtcsi_cmp.sv @@
// ----------------------------------------------------------------------------
// mtcsi_cmp
// Digit-serial compare of observation and both forecasts against all
// thresholds, least significant digit first.
// ----------------------------------------------------------------------------
module mtcsi_cmp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 start,
    input  logic [mtcsi_pkg::SAMPLE_W-1:0]       obs_value,
    input  logic                                 obs_valid,
    input  logic [mtcsi_pkg::SAMPLE_W-1:0]       plain_value,
    input  logic                                 plain_valid,
    input  logic [mtcsi_pkg::SAMPLE_W-1:0]       adjusted_value,
    input  logic                                 adjusted_valid,
    input  mtcsi_pkg::thr_vec_t                  thr,
    output logic                                 done,
    output mtcsi_pkg::yes_flags_t                yes
);

    localparam int SLOTS   = mtcsi_pkg::SLOTS;
    localparam int DIGIT_W = mtcsi_pkg::DIGIT_W;
    localparam int DCNT_W  = mtcsi_pkg::DCNT_W;

    logic                              busy_reg;
    logic                              done_reg;
    logic [DCNT_W-1:0]                 dig_cnt_reg;
    logic [mtcsi_pkg::SAMPLE_W-1:0]    sh_obs_reg;
    logic [mtcsi_pkg::SAMPLE_W-1:0]    sh_plain_reg;
    logic [mtcsi_pkg::SAMPLE_W-1:0]    sh_adj_reg;
    mtcsi_pkg::thr_vec_t               sh_thr_reg;
    logic                              vld_obs_reg;
    logic                              vld_plain_reg;
    logic                              vld_adj_reg;
    logic [SLOTS-1:0]                  gt_obs_reg;
    logic [SLOTS-1:0]                  gt_plain_reg;
    logic [SLOTS-1:0]                  gt_adj_reg;
    logic [SLOTS-1:0]                  gt_obs_next;
    logic [SLOTS-1:0]                  gt_plain_next;
    logic [SLOTS-1:0]                  gt_adj_next;
    mtcsi_pkg::yes_flags_t             yes_reg;
    logic                              top_dig;

    assign top_dig = (dig_cnt_reg == DCNT_W'(mtcsi_pkg::NUM_DIGITS - 1));

    always_comb begin
        logic [DIGIT_W-1:0] td;
        td = '0;
        for (int t = 0; t < SLOTS; t++) begin
            td = sh_thr_reg[t][DIGIT_W-1:0];
            gt_obs_next[t] = mtcsi_pkg::dig_gt(sh_obs_reg[DIGIT_W-1:0], td, top_dig)
                | ((sh_obs_reg[DIGIT_W-1:0] == td) & gt_obs_reg[t]);
            gt_plain_next[t] = mtcsi_pkg::dig_gt(sh_plain_reg[DIGIT_W-1:0], td, top_dig)
                | ((sh_plain_reg[DIGIT_W-1:0] == td) & gt_plain_reg[t]);
            gt_adj_next[t] = mtcsi_pkg::dig_gt(sh_adj_reg[DIGIT_W-1:0], td, top_dig)
                | ((sh_adj_reg[DIGIT_W-1:0] == td) & gt_adj_reg[t]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
            dig_cnt_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg    <= 1'b1;
                dig_cnt_reg <= '0;
            end else if (busy_reg) begin
                dig_cnt_reg <= dig_cnt_reg + 1'b1;
                if (top_dig) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            sh_obs_reg    <= obs_value;
            sh_plain_reg  <= plain_value;
            sh_adj_reg    <= adjusted_value;
            sh_thr_reg    <= thr;
            vld_obs_reg   <= obs_valid;
            vld_plain_reg <= plain_valid;
            vld_adj_reg   <= adjusted_valid;
            gt_obs_reg    <= '0;
            gt_plain_reg  <= '0;
            gt_adj_reg    <= '0;
        end else if (busy_reg) begin
            sh_obs_reg   <= sh_obs_reg >> DIGIT_W;
            sh_plain_reg <= sh_plain_reg >> DIGIT_W;
            sh_adj_reg   <= sh_adj_reg >> DIGIT_W;
            for (int t = 0; t < SLOTS; t++) begin
                sh_thr_reg[t] <= sh_thr_reg[t] >> DIGIT_W;
            end
            gt_obs_reg   <= gt_obs_next;
            gt_plain_reg <= gt_plain_next;
            gt_adj_reg   <= gt_adj_next;
            if (top_dig) begin
                yes_reg.obs   <= gt_obs_next & {SLOTS{vld_obs_reg}};
                yes_reg.plain <= gt_plain_next & {SLOTS{vld_plain_reg}};
                yes_reg.adj   <= gt_adj_next & {SLOTS{vld_adj_reg}};
            end
        end
    end

    assign done = done_reg;
    assign yes  = yes_reg;

endmodule

@@ rtl/core/mtcsi_div.sv @@
// ----------------------------------------------------------------------------
// mtcsi_div
// Restoring divider, one quotient bit per cycle: hits * 2^15 / denominator,
// zero for an empty denominator.
// ----------------------------------------------------------------------------
module mtcsi_div #(
    parameter int CNT_W = mtcsi_pkg::DEF_POINT_COUNT_LOG2 + 1
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [CNT_W-1:0]              hits,
    input  logic [CNT_W+1:0]              den,
    output logic                          done,
    output logic [mtcsi_pkg::CSI_W-1:0]   quo
);

    localparam int CSI_W  = mtcsi_pkg::CSI_W;
    localparam int STEP_W = $clog2(CSI_W);

    logic                  busy_reg;
    logic                  done_reg;
    logic                  first_reg;
    logic                  zero_reg;
    logic [STEP_W-1:0]     step_reg;
    logic [CNT_W+1:0]      rem_reg;
    logic [CNT_W+1:0]      rem_next;
    logic [CNT_W+1:0]      den_reg;
    logic [CSI_W-1:0]      quo_reg;
    logic [CNT_W+2:0]      trial;
    logic [CNT_W+2:0]      diff;
    logic                  ge;

    // first step has no shift since hits never exceed the denominator
    always_comb begin
        trial    = first_reg ? {1'b0, rem_reg} : {rem_reg, 1'b0};
        diff     = trial - {1'b0, den_reg};
        ge       = trial >= {1'b0, den_reg};
        rem_next = ge ? diff[CNT_W+1:0] : trial[CNT_W+1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_W'(CSI_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg   <= {2'b00, hits};
            den_reg   <= den;
            zero_reg  <= (den == '0);
            first_reg <= 1'b1;
            quo_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg   <= rem_next;
            first_reg <= 1'b0;
            quo_reg   <= {quo_reg[CSI_W-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = zero_reg ? '0 : quo_reg;

endmodule

@@ rtl/core/multi_threshold_csi_compare_top.sv @@
// ----------------------------------------------------------------------------
// multi_threshold_csi_compare_top
// Counts hits, misses and false alarms of two forecasts at several
// thresholds over a grid and scores them by critical success index.
// ----------------------------------------------------------------------------
// Each grid point item is accepted, then compared digit-serially (4-bit
// digits of the 16-bit samples against all thresholds at once), and then
// its outcome updates the saturating counters. An item with last_point set
// then starts scoring: each of the 2*NUM_THRESHOLDS forecast/threshold pairs
// runs through one shared divider producing one quotient bit per cycle,
// followed by a multiply and accumulate. The result item is held in an
// output register, so grid points of the next grid are taken while it
// waits; a further scoring pass waits until that result is taken.
// ----------------------------------------------------------------------------
module multi_threshold_csi_compare_top #(
    parameter int NUM_THRESHOLDS   = mtcsi_pkg::DEF_NUM_THRESHOLDS,
    parameter int POINT_COUNT_LOG2 = mtcsi_pkg::DEF_POINT_COUNT_LOG2
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                cfg_wr_en,
    input  logic [mtcsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [mtcsi_pkg::CFG_DATA_W-1:0]    cfg_wr_data,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [15:0]                  s_obs_value,
    input  logic                                s_obs_valid,
    input  logic signed [15:0]                  s_plain_value,
    input  logic                                s_plain_valid,
    input  logic signed [15:0]                  s_adjusted_value,
    input  logic                                s_adjusted_valid,
    input  logic                                s_last_point,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [15:0]                         m_plain_csi_0,
    output logic [15:0]                         m_plain_csi_1,
    output logic [15:0]                         m_plain_csi_2,
    output logic [15:0]                         m_plain_csi_3,
    output logic [15:0]                         m_adjusted_csi_0,
    output logic [15:0]                         m_adjusted_csi_1,
    output logic [15:0]                         m_adjusted_csi_2,
    output logic [15:0]                         m_adjusted_csi_3,
    output logic [17:0]                         m_plain_total,
    output logic [17:0]                         m_adjusted_total,
    output logic                                m_prefer_adjusted
);

    localparam int SLOTS      = mtcsi_pkg::SLOTS;
    localparam int SLOT_W     = mtcsi_pkg::SLOT_W;
    localparam int SLOT_IDX_W = mtcsi_pkg::SLOT_IDX_W;
    localparam int CSI_W      = mtcsi_pkg::CSI_W;
    localparam int WEIGHT_W   = mtcsi_pkg::WEIGHT_W;
    localparam int PROD_W     = mtcsi_pkg::PROD_W;
    localparam int ACC_W      = mtcsi_pkg::ACC_W;
    localparam int TOTAL_W    = mtcsi_pkg::TOTAL_W;
    localparam int CNT_W      = POINT_COUNT_LOG2 + 1;

    mtcsi_pkg::state_t          state_reg;
    mtcsi_pkg::state_t          state_next;
    mtcsi_pkg::ctrl_t           ctrl;

    mtcsi_pkg::thr_vec_t        thr_reg;
    logic [WEIGHT_W-1:0]        weight_reg [SLOTS];

    logic [CNT_W-1:0]           hit_reg  [2*SLOTS];
    logic [CNT_W-1:0]           miss_reg [2*SLOTS];
    logic [CNT_W-1:0]           fa_reg   [2*SLOTS];
    logic [CNT_W-1:0]           hit_next  [2*SLOTS];
    logic [CNT_W-1:0]           miss_next [2*SLOTS];
    logic [CNT_W-1:0]           fa_next   [2*SLOTS];

    logic                       last_reg;
    logic [SLOT_IDX_W-1:0]      slot_reg;
    logic [SLOT_W-1:0]          slot_t;
    logic                       skip;
    logic [CSI_W-1:0]           csi_reg [2*SLOTS];
    logic [PROD_W-1:0]          prod_reg;
    logic [ACC_W-1:0]           acc_reg [2];

    logic                       m_valid_reg;
    logic                       out_free;
    logic [CSI_W-1:0]           out_csi_reg [2*SLOTS];
    logic [TOTAL_W-1:0]         out_ptot_reg;
    logic [TOTAL_W-1:0]         out_atot_reg;
    logic                       out_pref_reg;

    logic                       cmp_done;
    mtcsi_pkg::yes_flags_t      yes;
    logic                       div_done;
    logic [CSI_W-1:0]           div_quo;
    logic [CNT_W+1:0]           den;

    // ---------------------------------------------------------------- config
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= '0;
            for (int t = 0; t < SLOTS; t++) begin
                weight_reg[t] <= (t == 0) ? mtcsi_pkg::WEIGHT0_RESET : '0;
            end
        end else if (cfg_wr_en) begin
            unique case (mtcsi_pkg::cfg_reg_t'(cfg_index)) inside
                mtcsi_pkg::REG_THRESHOLD_0, mtcsi_pkg::REG_THRESHOLD_1,
                mtcsi_pkg::REG_THRESHOLD_2, mtcsi_pkg::REG_THRESHOLD_3: begin
                    thr_reg[cfg_index[SLOT_W-1:0]] <= cfg_wr_data;
                end
                mtcsi_pkg::REG_WEIGHT_0, mtcsi_pkg::REG_WEIGHT_1,
                mtcsi_pkg::REG_WEIGHT_2, mtcsi_pkg::REG_WEIGHT_3: begin
                    weight_reg[cfg_index[SLOT_W-1:0]] <= cfg_wr_data;
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------------------------------------------------------- units
    mtcsi_cmp u_cmp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .start          (ctrl.cmp_start),
        .obs_value      (s_obs_value),
        .obs_valid      (s_obs_valid),
        .plain_value    (s_plain_value),
        .plain_valid    (s_plain_valid),
        .adjusted_value (s_adjusted_value),
        .adjusted_valid (s_adjusted_valid),
        .thr            (thr_reg),
        .done           (cmp_done),
        .yes            (yes)
    );

    assign den = {2'b00, hit_reg[slot_reg]} + {2'b00, miss_reg[slot_reg]}
               + {2'b00, fa_reg[slot_reg]};

    mtcsi_div #(
        .CNT_W (CNT_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (ctrl.div_start),
        .hits    (hit_reg[slot_reg]),
        .den     (den),
        .done    (div_done),
        .quo     (div_quo)
    );

    // ---------------------------------------------------------------- fsm
    assign slot_t   = slot_reg[SLOT_W-1:0];
    assign skip     = (32'(slot_t) >= NUM_THRESHOLDS);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mtcsi_pkg::ST_IDLE: begin
                if (s_valid) state_next = mtcsi_pkg::ST_CMP;
            end
            mtcsi_pkg::ST_CMP: begin
                if (cmp_done) begin
                    state_next = last_reg ? mtcsi_pkg::ST_DIV_START : mtcsi_pkg::ST_IDLE;
                end
            end
            mtcsi_pkg::ST_DIV_START: begin
                state_next = skip ? mtcsi_pkg::ST_NEXT : mtcsi_pkg::ST_DIV;
            end
            mtcsi_pkg::ST_DIV: begin
                if (div_done) state_next = mtcsi_pkg::ST_MUL;
            end
            mtcsi_pkg::ST_MUL: begin
                state_next = mtcsi_pkg::ST_ACC;
            end
            mtcsi_pkg::ST_ACC: begin
                state_next = mtcsi_pkg::ST_NEXT;
            end
            mtcsi_pkg::ST_NEXT: begin
                if (slot_reg == SLOT_IDX_W'(2 * SLOTS - 1)) begin
                    state_next = mtcsi_pkg::ST_OUT;
                end else begin
                    state_next = mtcsi_pkg::ST_DIV_START;
                end
            end
            mtcsi_pkg::ST_OUT: begin
                if (out_free) state_next = mtcsi_pkg::ST_IDLE;
            end
            default: state_next = mtcsi_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        ctrl = '0;
        unique case (state_reg)
            mtcsi_pkg::ST_IDLE: begin
                ctrl.s_ready   = 1'b1;
                ctrl.cmp_start = s_valid;
            end
            mtcsi_pkg::ST_CMP: begin
                ctrl.cnt_upd = cmp_done;
            end
            mtcsi_pkg::ST_DIV_START: begin
                ctrl.div_start = !skip;
                ctrl.csi_wr    = skip;
            end
            mtcsi_pkg::ST_DIV: begin
                ctrl.csi_wr = div_done;
            end
            mtcsi_pkg::ST_MUL: begin
                ctrl.mul_en = 1'b1;
            end
            mtcsi_pkg::ST_ACC: begin
                ctrl.acc_en = 1'b1;
            end
            mtcsi_pkg::ST_NEXT: begin
                ctrl.slot_inc = 1'b1;
            end
            mtcsi_pkg::ST_OUT: begin
                ctrl.out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mtcsi_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ---------------------------------------------------------------- counters
    always_comb begin
        logic oyes;
        logic fyes;
        oyes = 1'b0;
        fyes = 1'b0;
        for (int s = 0; s < 2 * SLOTS; s++) begin
            hit_next[s]  = hit_reg[s];
            miss_next[s] = miss_reg[s];
            fa_next[s]   = fa_reg[s];
            oyes = yes.obs[s % SLOTS];
            fyes = (s < SLOTS) ? yes.plain[s % SLOTS] : yes.adj[s % SLOTS];
            if (ctrl.out_load) begin
                hit_next[s]  = '0;
                miss_next[s] = '0;
                fa_next[s]   = '0;
            end else if (ctrl.cnt_upd && ((s % SLOTS) < NUM_THRESHOLDS)) begin
                // counters stick at all ones
                if (oyes && fyes) begin
                    if (hit_reg[s] != '1) hit_next[s] = hit_reg[s] + 1'b1;
                end else if (oyes) begin
                    if (miss_reg[s] != '1) miss_next[s] = miss_reg[s] + 1'b1;
                end else if (fyes) begin
                    if (fa_reg[s] != '1) fa_next[s] = fa_reg[s] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < 2 * SLOTS; s++) begin
                hit_reg[s]  <= '0;
                miss_reg[s] <= '0;
                fa_reg[s]   <= '0;
            end
        end else begin
            hit_reg  <= hit_next;
            miss_reg <= miss_next;
            fa_reg   <= fa_next;
        end
    end

    // ---------------------------------------------------------------- scoring
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg   <= 1'b0;
            slot_reg   <= '0;
            acc_reg[0] <= '0;
            acc_reg[1] <= '0;
        end else begin
            if (ctrl.cmp_start) last_reg <= s_last_point;
            if (ctrl.slot_inc) slot_reg <= slot_reg + 1'b1;
            if (ctrl.acc_en) begin
                acc_reg[slot_reg[SLOT_W]] <= acc_reg[slot_reg[SLOT_W]] + ACC_W'(prod_reg);
            end else if (ctrl.out_load) begin
                acc_reg[0] <= '0;
                acc_reg[1] <= '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.csi_wr) csi_reg[slot_reg] <= skip ? '0 : div_quo;
        if (ctrl.mul_en) prod_reg <= PROD_W'(div_quo) * PROD_W'(weight_reg[slot_t]);
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctrl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load) begin
            out_csi_reg  <= csi_reg;
            out_ptot_reg <= acc_reg[0][mtcsi_pkg::CSI_FRAC +: TOTAL_W];
            out_atot_reg <= acc_reg[1][mtcsi_pkg::CSI_FRAC +: TOTAL_W];
            out_pref_reg <= acc_reg[1][mtcsi_pkg::CSI_FRAC +: TOTAL_W]
                          > acc_reg[0][mtcsi_pkg::CSI_FRAC +: TOTAL_W];
        end
    end

    // no item is taken while reset is held
    assign s_ready           = ctrl.s_ready && aresetn;
    assign m_valid           = m_valid_reg;
    assign m_plain_csi_0     = out_csi_reg[0];
    assign m_plain_csi_1     = out_csi_reg[1];
    assign m_plain_csi_2     = out_csi_reg[2];
    assign m_plain_csi_3     = out_csi_reg[3];
    assign m_adjusted_csi_0  = out_csi_reg[SLOTS + 0];
    assign m_adjusted_csi_1  = out_csi_reg[SLOTS + 1];
    assign m_adjusted_csi_2  = out_csi_reg[SLOTS + 2];
    assign m_adjusted_csi_3  = out_csi_reg[SLOTS + 3];
    assign m_plain_total     = out_ptot_reg;
    assign m_adjusted_total  = out_atot_reg;
    assign m_prefer_adjusted = out_pref_reg;

endmodule

@@ test/multi_threshold_csi_compare_top_test.sv @@
// ----------------------------------------------------------------------------
// multi_threshold_csi_compare_top_test
// Streams grids of points through the CSI compare block under several
// threshold and weight settings, with random gaps on both channels and one
// long output stall. A local scorer counts hits, misses and false alarms per
// threshold and forecast and checks every score item field by field.
// ----------------------------------------------------------------------------
module multi_threshold_csi_compare_top_test;

    import mtcsi_pkg::*;

    localparam int CNT_W        = DEF_POINT_COUNT_LOG2 + 1;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 400;
    localparam int HOLD_CYCLES  = 1500;

    typedef struct packed {
        logic [15:0] obs_value;
        logic        obs_valid;
        logic [15:0] plain_value;
        logic        plain_valid;
        logic [15:0] adjusted_value;
        logic        adjusted_valid;
        logic        last_point;
    } grid_point_t;

    typedef struct packed {
        logic [SLOTS-1:0][15:0] plain_csi;
        logic [SLOTS-1:0][15:0] adjusted_csi;
        logic [17:0]            plain_total;
        logic [17:0]            adjusted_total;
        logic                   prefer_adjusted;
    } score_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wr_data = '0;

    logic        s_valid = 1'b0;
    logic        s_ready;
    grid_point_t offered = '0;

    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_plain_csi_0, m_plain_csi_1, m_plain_csi_2, m_plain_csi_3;
    logic [15:0] m_adjusted_csi_0, m_adjusted_csi_1, m_adjusted_csi_2, m_adjusted_csi_3;
    logic [17:0] m_plain_total, m_adjusted_total;
    logic        m_prefer_adjusted;

    // scorer copy of the registers and counters
    thr_vec_t               thr_cfg = '0;
    logic [SLOTS-1:0][15:0] wgt_cfg = {16'd0, 16'd0, 16'd0, WEIGHT0_RESET};
    logic [CNT_W-1:0]       hit_cnt [2*SLOTS];
    logic [CNT_W-1:0]       miss_cnt [2*SLOTS];
    logic [CNT_W-1:0]       false_alarm_cnt [2*SLOTS];

    grid_point_t grid_points [$];
    score_t      expected_scores [$];

    logic point_taken = 1'b0;
    int   idle_pct = 31;
    logic hold_request = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;
    int   cycle_count = 0;
    int   fail_count = 0;
    int   points_taken = 0;
    int   grids_scored = 0;
    int   adjusted_wins = 0;

    multi_threshold_csi_compare_top u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wr_data       (cfg_wr_data),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_obs_value       (offered.obs_value),
        .s_obs_valid       (offered.obs_valid),
        .s_plain_value     (offered.plain_value),
        .s_plain_valid     (offered.plain_valid),
        .s_adjusted_value  (offered.adjusted_value),
        .s_adjusted_valid  (offered.adjusted_valid),
        .s_last_point      (offered.last_point),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_plain_csi_0     (m_plain_csi_0),
        .m_plain_csi_1     (m_plain_csi_1),
        .m_plain_csi_2     (m_plain_csi_2),
        .m_plain_csi_3     (m_plain_csi_3),
        .m_adjusted_csi_0  (m_adjusted_csi_0),
        .m_adjusted_csi_1  (m_adjusted_csi_1),
        .m_adjusted_csi_2  (m_adjusted_csi_2),
        .m_adjusted_csi_3  (m_adjusted_csi_3),
        .m_plain_total     (m_plain_total),
        .m_adjusted_total  (m_adjusted_total),
        .m_prefer_adjusted (m_prefer_adjusted)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    initial begin
        for (int s = 0; s < 2*SLOTS; s++) begin
            hit_cnt[s] = '0;
            miss_cnt[s] = '0;
            false_alarm_cnt[s] = '0;
        end
    end

    task automatic count_outcome(int slot, logic fyes, logic oyes);
        if (oyes && fyes) begin
            if (hit_cnt[slot] != {CNT_W{1'b1}}) hit_cnt[slot] = hit_cnt[slot] + 1'b1;
        end else if (oyes) begin
            if (miss_cnt[slot] != {CNT_W{1'b1}}) miss_cnt[slot] = miss_cnt[slot] + 1'b1;
        end else if (fyes) begin
            if (false_alarm_cnt[slot] != {CNT_W{1'b1}}) begin
                false_alarm_cnt[slot] = false_alarm_cnt[slot] + 1'b1;
            end
        end
    endtask

    function automatic logic [15:0] csi_of(int slot);
        logic [63:0] den;
        logic [63:0] quo;
        den = 64'(hit_cnt[slot]) + 64'(miss_cnt[slot]) + 64'(false_alarm_cnt[slot]);
        quo = (den == 0) ? 64'd0 : (64'(hit_cnt[slot]) << CSI_FRAC) / den;
        return quo[15:0];
    endfunction

    // tallies one grid point and, on the last one, scores the grid
    task automatic score_point(grid_point_t p);
        logic        oyes, pyes, ayes;
        logic [63:0] psum, asum;
        score_t      sc;
        psum = '0;
        asum = '0;
        sc = '0;
        for (int t = 0; t < SLOTS; t++) begin
            oyes = p.obs_valid && ($signed(p.obs_value) > $signed(thr_cfg[t]));
            pyes = p.plain_valid && ($signed(p.plain_value) > $signed(thr_cfg[t]));
            ayes = p.adjusted_valid && ($signed(p.adjusted_value) > $signed(thr_cfg[t]));
            count_outcome(t, pyes, oyes);
            count_outcome(SLOTS + t, ayes, oyes);
        end
        if (p.last_point) begin
            for (int t = 0; t < SLOTS; t++) begin
                sc.plain_csi[t] = csi_of(t);
                sc.adjusted_csi[t] = csi_of(SLOTS + t);
                psum += 64'(sc.plain_csi[t]) * 64'(wgt_cfg[t]);
                asum += 64'(sc.adjusted_csi[t]) * 64'(wgt_cfg[t]);
            end
            sc.plain_total = psum[CSI_FRAC +: TOTAL_W];
            sc.adjusted_total = asum[CSI_FRAC +: TOTAL_W];
            sc.prefer_adjusted = sc.adjusted_total > sc.plain_total;
            expected_scores.insert(expected_scores.size(), sc);
            for (int s = 0; s < 2*SLOTS; s++) begin
                hit_cnt[s] = '0;
                miss_cnt[s] = '0;
                false_alarm_cnt[s] = '0;
            end
        end
    endtask

    task automatic check_field(string name, logic [17:0] want, logic [17:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    // point driver
    always @(negedge aclk) begin : drive_points
        logic load;
        if (!s_valid || point_taken) begin
            load = (grid_points.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
            if (load) begin
                offered <= grid_points.pop_front();
            end
            s_valid <= load;
        end
    end

    // score receiver, with one long hold-off on request
    always @(negedge aclk) begin : drive_ready
        if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_request && !hold_done) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= idle_pct);
        end
    end

    always @(posedge aclk) begin : watch_ports
        score_t got;
        score_t want;
        point_taken <= s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            score_point(offered);
            points_taken++;
        end
        if (aresetn && m_valid && m_ready) begin
            got.plain_csi[0] = m_plain_csi_0;
            got.plain_csi[1] = m_plain_csi_1;
            got.plain_csi[2] = m_plain_csi_2;
            got.plain_csi[3] = m_plain_csi_3;
            got.adjusted_csi[0] = m_adjusted_csi_0;
            got.adjusted_csi[1] = m_adjusted_csi_1;
            got.adjusted_csi[2] = m_adjusted_csi_2;
            got.adjusted_csi[3] = m_adjusted_csi_3;
            got.plain_total = m_plain_total;
            got.adjusted_total = m_adjusted_total;
            got.prefer_adjusted = m_prefer_adjusted;
            if (expected_scores.size() == 0) begin
                $display("%0t unexpected score item: expected none, actual totals %0d/%0d",
                         $time, got.plain_total, got.adjusted_total);
                fail_count++;
            end else begin
                want = expected_scores.pop_front();
                for (int t = 0; t < SLOTS; t++) begin
                    check_field($sformatf("plain_csi_%0d", t),
                                18'(want.plain_csi[t]), 18'(got.plain_csi[t]));
                    check_field($sformatf("adjusted_csi_%0d", t),
                                18'(want.adjusted_csi[t]), 18'(got.adjusted_csi[t]));
                end
                check_field("plain_total", want.plain_total, got.plain_total);
                check_field("adjusted_total", want.adjusted_total, got.adjusted_total);
                check_field("prefer_adjusted", 18'(want.prefer_adjusted),
                            18'(got.prefer_adjusted));
                grids_scored++;
                if (want.prefer_adjusted) adjusted_wins++;
            end
        end
    end

    always @(posedge aclk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx <= REG_THRESHOLD_3) begin
            thr_cfg[int'(idx) - int'(REG_THRESHOLD_0)] = val;
        end else begin
            wgt_cfg[int'(idx) - int'(REG_WEIGHT_0)] = val;
        end
    endtask

    task automatic apply_setting(thr_vec_t thr, logic [SLOTS-1:0][15:0] wgt);
        for (int i = 0; i < SLOTS; i++) begin
            write_reg(cfg_reg_t'(int'(REG_THRESHOLD_0) + i), thr[i]);
            write_reg(cfg_reg_t'(int'(REG_WEIGHT_0) + i), wgt[i]);
        end
    endtask

    task automatic push_point(logic [15:0] ov, logic ovd, logic [15:0] pv, logic pvd,
                              logic [15:0] av, logic avd, logic last_point);
        grid_point_t p;
        p = '{ov, ovd, pv, pvd, av, avd, last_point};
        grid_points.insert(grid_points.size(), p);
    endtask

    // mostly close to a threshold, so that all three outcomes turn up
    function automatic logic [15:0] rand_sample();
        logic [15:0] v;
        if ($urandom_range(0, 99) < 70) begin
            v = thr_cfg[$urandom_range(0, SLOTS-1)] + 16'($urandom_range(0, 6)) - 16'd3;
        end else begin
            v = 16'($urandom);
        end
        return v;
    endfunction

    function automatic logic rand_flag();
        return $urandom_range(0, 99) < 85;
    endfunction

    task automatic queue_random_grids(int n_items, int max_len);
        int left;
        int len;
        left = n_items;
        while (left > 0) begin
            if ($urandom_range(0, 19) == 0) begin
                len = $urandom_range(max_len, 3*max_len);
            end else begin
                len = $urandom_range(1, max_len);
            end
            if (len > left) len = left;
            for (int k = 0; k < len; k++) begin
                push_point(rand_sample(), rand_flag(), rand_sample(), rand_flag(),
                           rand_sample(), rand_flag(), k == len - 1);
            end
            left -= len;
        end
    endtask

    // every grid ends on a last point, so once its score is in the block is idle
    task automatic drain_phase();
        while (grid_points.size() != 0 || s_valid || expected_scores.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin : run_phases
        thr_vec_t               thr;
        logic [SLOTS-1:0][15:0] wgt;

        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset setting: all thresholds zero, only the first weight set
        push_point(16'h7FFF, 1'b0, 16'h7FFF, 1'b0, 16'h7FFF, 1'b0, 1'b1);
        push_point(16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 16'h8000, 1'b1, 1'b0);
        push_point(16'h0000, 1'b1, 16'h0001, 1'b1, 16'h0000, 1'b1, 1'b0);
        push_point(16'h0001, 1'b1, 16'h0000, 1'b1, 16'h0001, 1'b0, 1'b0);
        push_point(16'h8000, 1'b1, 16'hFFFF, 1'b1, 16'h7FFF, 1'b1, 1'b1);
        push_point(16'h0100, 1'b1, 16'h0100, 1'b1, 16'h0100, 1'b1, 1'b1);
        drain_phase();

        // extreme thresholds, full weights
        thr = {16'h7FFF, 16'h0001, 16'hFFFF, 16'h8000};
        wgt = {16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        apply_setting(thr, wgt);
        push_point(16'h8000, 1'b1, 16'h8001, 1'b1, 16'h8000, 1'b1, 1'b0);
        push_point(16'h8001, 1'b1, 16'h8000, 1'b1, 16'h7FFF, 1'b1, 1'b0);
        push_point(16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 16'h7FFF, 1'b1, 1'b0);
        push_point(16'h0000, 1'b1, 16'h0000, 1'b1, 16'hFFFF, 1'b1, 1'b0);
        push_point(16'h0001, 1'b1, 16'h0002, 1'b1, 16'h0001, 1'b1, 1'b0);
        push_point(16'h5555, 1'b1, 16'hAAAA, 1'b1, 16'h5555, 1'b0, 1'b0);
        push_point(16'hAAAA, 1'b1, 16'h5555, 1'b1, 16'hAAAA, 1'b1, 1'b1);
        push_point(16'h0064, 1'b1, 16'h0064, 1'b1, 16'h0064, 1'b1, 1'b1);
        push_point(16'h0064, 1'b1, 16'hFF9C, 1'b1, 16'h0064, 1'b1, 1'b1);
        queue_random_grids(130, 12);
        drain_phase();

        // no gaps on either side for this stretch
        thr = {16'h0200, 16'hFF00, 16'h0100, 16'h0000};
        wgt = {16'h2000, 16'h0000, 16'h1000, 16'h1000};
        apply_setting(thr, wgt);
        idle_pct = 0;
        queue_random_grids(140, 12);
        drain_phase();
        idle_pct = 31;

        // narrow random thresholds, random weights, long output stall
        for (int i = 0; i < SLOTS; i++) begin
            thr[i] = 16'($urandom_range(0, 2048)) - 16'd1024;
            wgt[i] = 16'($urandom);
        end
        apply_setting(thr, wgt);
        hold_request = 1'b1;
        queue_random_grids(150, 10);
        drain_phase();

        // nothing rises above the top threshold and every weight is zero
        thr = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
        wgt = '0;
        apply_setting(thr, wgt);
        queue_random_grids(80, 12);
        drain_phase();

        // fully random setting
        for (int i = 0; i < SLOTS; i++) begin
            thr[i] = 16'($urandom);
            wgt[i] = 16'($urandom);
        end
        apply_setting(thr, wgt);
        queue_random_grids(180, 14);
        drain_phase();

        $display("run covered %0d grid points and %0d scored grids over six settings",
                 points_taken, grids_scored);
        $display("adjusted forecast ahead in %0d grids, plain or tied in %0d",
                 adjusted_wins, grids_scored - adjusted_wins);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/mtcsi_pkg.sv
rtl/core/mtcsi_cmp.sv
rtl/core/mtcsi_div.sv
rtl/core/multi_threshold_csi_compare_top.sv
test/multi_threshold_csi_compare_top_test.sv
